### design/psr_pkg.sv
`default_nettype none

package psr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int STEP_W    = 16;
    localparam int PHASE_W   = 17;
    localparam int GAIN_FRAC = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int PC_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE  = 2'd3;

    localparam logic [STEP_W-1:0] PITCH_STEP_RST = 16'd4096;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd2896;

    typedef logic [PC_W-1:0] t_pc;

    // Program addresses
    localparam t_pc A_WAIT  = 4'd0;
    localparam t_pc A_PRCHK = 4'd1;
    localparam t_pc A_CHK   = 4'd2;
    localparam t_pc A_RUNCK = 4'd3;
    localparam t_pc A_MIX_L = 4'd4;
    localparam t_pc A_GN_L  = 4'd5;
    localparam t_pc A_RND_L = 4'd6;
    localparam t_pc A_MIX_R = 4'd7;
    localparam t_pc A_GN_R  = 4'd8;
    localparam t_pc A_RND_R = 4'd9;
    localparam t_pc A_EMIT  = 4'd10;
    localparam t_pc A_LOOP  = 4'd11;
    localparam t_pc A_SKIP  = 4'd12;
    localparam t_pc A_FIN   = 4'd13;
    localparam t_pc A_PRIME = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_PRIME,
        OP_MIX_L,
        OP_MIX_R,
        OP_GAIN_L,
        OP_GAIN_R,
        OP_ROUND_L,
        OP_ROUND_R,
        OP_EMIT,
        OP_ADD_STEP,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_UNPRIMED,
        C_PHASE_HI,
        C_RUN_FULL,
        C_OUT_BUSY,
        C_NEXT_LOW
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic primed;
        logic phase_hi;
        logic run_full;
        logic out_busy;
        logic next_low;
    } t_status;

    // Microprogram: branch to target when cond holds, else fall through.
    function automatic t_ctrl ucode(input t_pc addr);
        t_ctrl w;
        case (addr)
            A_WAIT:  w = '{OP_LATCH,    C_NO_IN,    A_WAIT};
            A_PRCHK: w = '{OP_NOP,      C_UNPRIMED, A_PRIME};
            A_CHK:   w = '{OP_NOP,      C_PHASE_HI, A_FIN};
            A_RUNCK: w = '{OP_NOP,      C_RUN_FULL, A_SKIP};
            A_MIX_L: w = '{OP_MIX_L,    C_NONE,     A_WAIT};
            A_GN_L:  w = '{OP_GAIN_L,   C_NONE,     A_WAIT};
            A_RND_L: w = '{OP_ROUND_L,  C_NONE,     A_WAIT};
            A_MIX_R: w = '{OP_MIX_R,    C_NONE,     A_WAIT};
            A_GN_R:  w = '{OP_GAIN_R,   C_NONE,     A_WAIT};
            A_RND_R: w = '{OP_ROUND_R,  C_NONE,     A_WAIT};
            A_EMIT:  w = '{OP_EMIT,     C_OUT_BUSY, A_EMIT};
            A_LOOP:  w = '{OP_NOP,      C_ALWAYS,   A_CHK};
            A_SKIP:  w = '{OP_ADD_STEP, C_NEXT_LOW, A_SKIP};
            A_FIN:   w = '{OP_FINISH,   C_ALWAYS,   A_WAIT};
            A_PRIME: w = '{OP_PRIME,    C_ALWAYS,   A_WAIT};
            default: w = '{OP_NOP,      C_ALWAYS,   A_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### design/psr_if.sv
`default_nettype none

interface psr_in_if import psr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface psr_out_if import psr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;

    modport source (output valid, output out_left, output out_right, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input last_of_run,
                    output ready);
endinterface

interface psr_cfg_if import psr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/psr_sequencer.sv
`default_nettype none

module psr_sequencer import psr_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_status i_stat,
    output t_ctrl   o_ctrl
);

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;
    logic  w_take;

    assign w_ctrl = ucode(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.cond)
            C_NONE:     w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = !i_stat.in_fire;
            C_UNPRIMED: w_take = !i_stat.primed;
            C_PHASE_HI: w_take = i_stat.phase_hi;
            C_RUN_FULL: w_take = i_stat.run_full;
            C_OUT_BUSY: w_take = i_stat.out_busy;
            C_NEXT_LOW: w_take = i_stat.next_low;
            default:    w_take = 1'b0;
        endcase
        n_pc = w_take ? w_ctrl.target : t_pc'(r_pc + t_pc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

### design/psr_datapath.sv
`default_nettype none

module psr_datapath import psr_pkg::*; #(
    parameter int FRAC_BITS = 12,
    parameter int MAX_RUN   = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_ctrl              i_ctrl,
    output t_status            o_stat,
    input  wire [STEP_W-1:0]   i_step,
    input  wire [GAIN_W-1:0]   i_gain_left,
    input  wire [GAIN_W-1:0]   i_gain_right,
    input  wire                i_mono,
    psr_in_if.sink             i_in,
    psr_out_if.source          o_out
);

    localparam int MIX_W  = FRAC_BITS + 17;
    localparam int DF_W   = FRAC_BITS + 18;
    localparam int PROD_W = MIX_W + 17;
    localparam int SH     = FRAC_BITS + GAIN_FRAC;
    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam logic [PHASE_W-1:0]       PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND      = PROD_W'(1) <<< (SH - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_LO   = PROD_W'(-32768);

    logic signed [SAMPLE_W-1:0] r_cur_l, r_cur_r, r_prev_l, r_prev_r;
    logic signed [SAMPLE_W-1:0] r_res_l, r_res_r;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;
    logic                       r_out_last;
    logic                       r_out_valid;
    logic signed [MIX_W-1:0]    r_mix;
    logic signed [PROD_W-1:0]   r_prod;
    logic [PHASE_W-1:0]         r_phase;
    logic [RUN_W-1:0]           r_run;
    logic                       r_primed;

    logic signed [SAMPLE_W-1:0] w_a, w_b;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [FRAC_BITS:0]  w_frac;
    logic signed [DF_W-1:0]     w_dfrac;
    logic signed [MIX_W-1:0]    w_mix;
    logic signed [GAIN_W:0]     w_gain;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_shr;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic [PHASE_W-1:0]         w_phase_step;
    logic [RUN_W-1:0]           w_run_inc;
    logic                       w_in_fire;
    logic                       w_out_busy;
    logic                       w_emit;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_busy = r_out_valid && !o_out.ready;
    assign w_emit     = (i_ctrl.op == OP_EMIT) && !w_out_busy;

    // prev*(1-frac) + cur*frac, folded to prev + (cur-prev)*frac
    always_comb begin
        w_a     = (i_ctrl.op == OP_MIX_R) ? r_prev_r : r_prev_l;
        w_b     = (i_ctrl.op == OP_MIX_R) ? r_cur_r  : r_cur_l;
        w_diff  = (SAMPLE_W+1)'(w_b) - (SAMPLE_W+1)'(w_a);
        w_frac  = $signed({1'b0, r_phase[FRAC_BITS-1:0]});
        w_dfrac = DF_W'(w_diff) * DF_W'(w_frac);
        w_mix   = MIX_W'(w_dfrac) + (MIX_W'(w_a) <<< FRAC_BITS);
    end

    always_comb begin
        w_gain = $signed({1'b0, (i_ctrl.op == OP_GAIN_R) ? i_gain_right : i_gain_left});
        w_prod = PROD_W'(r_mix) * PROD_W'(w_gain);
    end

    // Round half up, then clamp to 16 bits
    always_comb begin
        w_shr = (r_prod + RND) >>> SH;
        if (w_shr > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_W-1:0];
        end else if (w_shr < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_W-1:0];
        end else begin
            w_sat = w_shr[SAMPLE_W-1:0];
        end
    end

    assign w_phase_step = r_phase + PHASE_W'(i_step);
    assign w_run_inc    = RUN_W'(r_run + RUN_W'(1));

    assign o_stat.in_fire  = w_in_fire;
    assign o_stat.primed   = r_primed;
    assign o_stat.phase_hi = (r_phase >= PHASE_ONE);
    assign o_stat.run_full = (r_run == RUN_W'(MAX_RUN));
    assign o_stat.out_busy = w_out_busy;
    assign o_stat.next_low = (w_phase_step < PHASE_ONE);

    assign i_in.ready        = (i_ctrl.op == OP_LATCH);
    assign o_out.valid       = r_out_valid;
    assign o_out.out_left    = r_out_l;
    assign o_out.out_right   = r_out_r;
    assign o_out.last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_run       <= '0;
            r_primed    <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.op)
                OP_PRIME: begin
                    r_primed <= 1'b1;
                end
                OP_EMIT: begin
                    if (!w_out_busy) begin
                        r_phase <= w_phase_step;
                        r_run   <= w_run_inc;
                    end
                end
                OP_ADD_STEP: begin
                    r_phase <= w_phase_step;
                end
                OP_FINISH: begin
                    r_phase <= r_phase - PHASE_ONE;
                    r_run   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cur_l <= i_in.sample_left;
            r_cur_r <= i_mono ? i_in.sample_left : i_in.sample_right;
        end
        if (w_emit) begin
            r_out_l    <= r_res_l;
            r_out_r    <= r_res_r;
            r_out_last <= !o_stat.next_low || (w_run_inc == RUN_W'(MAX_RUN));
        end
        case (i_ctrl.op)
            OP_MIX_L, OP_MIX_R: begin
                r_mix <= w_mix;
            end
            OP_GAIN_L, OP_GAIN_R: begin
                r_prod <= w_prod;
            end
            OP_ROUND_L: begin
                r_res_l <= w_sat;
            end
            OP_ROUND_R: begin
                r_res_r <= w_sat;
            end
            OP_PRIME, OP_FINISH: begin
                r_prev_l <= r_cur_l;
                r_prev_r <= r_cur_r;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### design/pitched_stereo_resampler_core.sv
`default_nettype none

// Channel  Dir  Payload                                 Request on
// i_in     in   sample_left, sample_right               valid && ready
// o_out    out  out_left, out_right, last_of_run        valid && ready
// i_cfg    in   index (0 pitch, 1 gain L, 2 gain R,     valid && ready (ready tied high)
//               3 mono), data
//
// A microprogram of 15 control words runs one shared multiply/round datapath.
// A run cut at MAX_RUN adds phase-skip steps until the phase reaches one.
// Input is taken only at the wait step; the output register holds one pair, so
// a stalled sink stalls the emit step and nothing else. Reset is synchronous.

module pitched_stereo_resampler_core import psr_pkg::*; #(
    parameter int FRAC_BITS = 12,
    parameter int MAX_RUN   = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    psr_in_if.sink     i_in,
    psr_out_if.source  o_out,
    psr_cfg_if.sink    i_cfg
);

    logic [STEP_W-1:0] r_pitch_step;
    logic [GAIN_W-1:0] r_gain_left;
    logic [GAIN_W-1:0] r_gain_right;
    logic              r_mono;
    logic [STEP_W-1:0] w_step;
    t_ctrl             w_ctrl;
    t_status           w_stat;

    assign i_cfg.ready = 1'b1;

    // A zero step advances by one LSB
    assign w_step = (r_pitch_step == '0) ? STEP_W'(1) : r_pitch_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_step <= PITCH_STEP_RST;
            r_gain_left  <= GAIN_RST;
            r_gain_right <= GAIN_RST;
            r_mono       <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PITCH_STEP: r_pitch_step <= i_cfg.data;
                CFG_GAIN_LEFT:  r_gain_left  <= i_cfg.data;
                CFG_GAIN_RIGHT: r_gain_right <= i_cfg.data;
                CFG_MONO_MODE:  r_mono       <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    psr_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    psr_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .i_step       (w_step),
        .i_gain_left  (r_gain_left),
        .i_gain_right (r_gain_right),
        .i_mono       (r_mono),
        .i_in         (i_in),
        .o_out        (o_out)
    );

    // A frame taken while unprimed leads, through the prime-check and prime steps, to the primed flag
    a_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && !w_stat.primed |-> ##3 w_stat.primed)
        else $error("priming frame did not set primed");

    // A pair leaves only with the phase below one and the run not full
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.op == OP_EMIT && !w_stat.out_busy |-> !w_stat.phase_hi && !w_stat.run_full)
        else $error("pair emitted outside a run");

    // Silent phase advance only happens after a run was cut short
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.op == OP_ADD_STEP |-> w_stat.run_full && !w_stat.phase_hi)
        else $error("phase skip outside a full run");

endmodule

`default_nettype wire
